@@ rtl/core/eae_pkg.sv @@
// Shared constants, types and the quarter-wave sine table for the ellipse arc end point core.
// No dependencies; eae_angle, eae_axis and the core top level use it by scoped names.
`timescale 1ns / 1ps

package eae_pkg;

    localparam int DEGREES_PER_TURN       = 360;
    localparam int QUARTER_TURN           = 90;
    localparam int HALF_TURN              = 180;
    localparam int THREE_QUARTER_TURN     = 270;
    localparam int TRIG_FRAC_BITS_DEFAULT = 15;

    localparam int FIELD_W      = 16;  // rectangle and centre fields
    localparam int ANGLE_W      = 10;  // angle fields
    localparam int COORD_W      = 17;  // result coordinates
    localparam int Q15_W        = 16;  // raw table entries, entry 90 is 2^15
    localparam int TABLE_DEPTH  = 91;  // sine of 0..90 degrees
    localparam int TABLE_ADDR_W = 7;

    // Per-point lookup plan: table addresses and sign rules.
    typedef struct packed {
        logic [TABLE_ADDR_W-1:0] addr_a;  // k
        logic [TABLE_ADDR_W-1:0] addr_b;  // 90 - k
        logic                    odd;     // odd quadrant swaps sine and cosine ports
        logic                    s_neg;   // sine value is negative
        logic                    c_neg;   // cosine value is negative
        logic                    x_pos;   // x offset keeps its magnitude
        logic                    y_pos;   // y offset keeps its magnitude
    } eae_point_t;

    typedef struct packed {
        logic trig_neg;
        logic positive;
    } eae_axis_ctl_t;

    function automatic logic [Q15_W-1:0] sine_q15(input logic [TABLE_ADDR_W-1:0] idx);
        logic [Q15_W-1:0] v;
        case (idx)
            7'd0:  v = 16'd0;     7'd1:  v = 16'd572;   7'd2:  v = 16'd1144;
            7'd3:  v = 16'd1715;  7'd4:  v = 16'd2286;  7'd5:  v = 16'd2856;
            7'd6:  v = 16'd3425;  7'd7:  v = 16'd3993;  7'd8:  v = 16'd4560;
            7'd9:  v = 16'd5126;  7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
            7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
            7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
            7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
            7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
            7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
            7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
            7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
            7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
            7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
            7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
            7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
            7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
            7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
            7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
            7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
            7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
            7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
            7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
            7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
            7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
            7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
            7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
            7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
            7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
            7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
            7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/eae_ram.sv @@
// Generic single-write, dual-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module eae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 91
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(DEPTH)-1:0]        waddr,
    input  logic [WIDTH-1:0]                wdata,
    input  logic [$clog2(DEPTH)-1:0]        raddr_a,
    input  logic [$clog2(DEPTH)-1:0]        raddr_b,
    output logic [WIDTH-1:0]                rdata_a,
    output logic [WIDTH-1:0]                rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ rtl/core/eae_angle.sv @@
// End angle, screen rotation and quadrant decode into table addresses and sign rules.
// Depends on eae_pkg.
`timescale 1ns / 1ps

module eae_angle (
    input  logic signed [eae_pkg::ANGLE_W-1:0] start_angle,
    input  logic signed [eae_pkg::ANGLE_W-1:0] arc_angle,
    output eae_pkg::eae_point_t                start_pt,
    output eae_pkg::eae_point_t                end_pt
);

    localparam logic signed [11:0] QTR_S  = 12'(eae_pkg::QUARTER_TURN);
    localparam logic signed [11:0] TURN_S = 12'(eae_pkg::DEGREES_PER_TURN);
    localparam logic [10:0] TURN_U  = 11'(eae_pkg::DEGREES_PER_TURN);
    localparam logic [10:0] TURN2_U = 11'(2 * eae_pkg::DEGREES_PER_TURN);

    function automatic logic signed [11:0] rotate(input logic signed [11:0] a);
        return (a <= QTR_S) ? (QTR_S - a) : (TURN_S + QTR_S - a);
    endfunction

    function automatic eae_pkg::eae_point_t point_info(input logic [9:0] a);
        logic [8:0]                           r;
        logic [1:0]                           q;
        logic [eae_pkg::TABLE_ADDR_W-1:0]     k;
        eae_pkg::eae_point_t                  p;
        r = (a >= 10'(eae_pkg::DEGREES_PER_TURN)) ? 9'(a - 10'(eae_pkg::DEGREES_PER_TURN))
                                                  : a[8:0];
        if (r < 9'(eae_pkg::QUARTER_TURN))
        begin
            q = 2'd0;
            k = r[6:0];
        end
        else if (r < 9'(eae_pkg::HALF_TURN))
        begin
            q = 2'd1;
            k = 7'(r - 9'(eae_pkg::QUARTER_TURN));
        end
        else if (r < 9'(eae_pkg::THREE_QUARTER_TURN))
        begin
            q = 2'd2;
            k = 7'(r - 9'(eae_pkg::HALF_TURN));
        end
        else
        begin
            q = 2'd3;
            k = 7'(r - 9'(eae_pkg::THREE_QUARTER_TURN));
        end
        p.addr_a = k;
        p.addr_b = 7'(eae_pkg::QUARTER_TURN) - k;
        p.odd    = q[0];
        p.s_neg  = q[1];
        p.c_neg  = q[0] ^ q[1];
        p.x_pos  = (a <= 10'(eae_pkg::QUARTER_TURN)) ||
                   ((a > 10'(eae_pkg::THREE_QUARTER_TURN)) &&
                    (a <= 10'(eae_pkg::DEGREES_PER_TURN)));
        p.y_pos  = (a > 10'(eae_pkg::HALF_TURN)) && (a <= 10'(eae_pkg::DEGREES_PER_TURN));
        return p;
    endfunction

    logic signed [10:0] sum;
    logic        [10:0] sum_mag;
    logic        [10:0] sum_red;
    logic signed [11:0] end_raw;
    logic signed [11:0] start_rot;
    logic signed [11:0] start_adj;
    logic signed [11:0] end_rot;

    always_comb
    begin
        // truncating remainder: reduce the magnitude, then restore the sign
        sum     = 11'(start_angle) + 11'(arc_angle);
        sum_mag = sum[10] ? 11'(-sum) : 11'(sum);
        if (sum_mag >= TURN2_U)
        begin
            sum_red = sum_mag - TURN2_U;
        end
        else if (sum_mag >= TURN_U)
        begin
            sum_red = sum_mag - TURN_U;
        end
        else
        begin
            sum_red = sum_mag;
        end
        end_raw = sum[10] ? -$signed({3'b000, sum_red[8:0]}) : $signed({3'b000, sum_red[8:0]});

        start_rot = rotate(12'(start_angle));
        start_adj = (start_rot < 12'sd0) ? (start_rot + TURN_S) : start_rot;
        end_rot   = rotate(end_raw);

        start_pt = point_info(start_adj[9:0]);
        end_pt   = point_info(end_rot[9:0]);
    end

endmodule

@@ rtl/core/eae_axis.sv @@
// One coordinate of one arc point: registered multiply, then rounding, forced sign and centre.
// Depends on eae_pkg.
`timescale 1ns / 1ps

module eae_axis #(
    parameter int FRAC_BITS = eae_pkg::TRIG_FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic [eae_pkg::FIELD_W-1:0]         full,
    input  logic [FRAC_BITS:0]                  trig,
    input  eae_pkg::eae_axis_ctl_t              ctl,
    input  logic signed [eae_pkg::FIELD_W-1:0]  center,
    output logic signed [eae_pkg::COORD_W-1:0]  value
);

    localparam int TW = FRAC_BITS + 1;
    localparam int PW = eae_pkg::FIELD_W + TW;
    localparam logic [PW-1:0] HALF = PW'(1) << FRAC_BITS;

    logic [PW-1:0]                       prod_reg;
    eae_pkg::eae_axis_ctl_t              ctl_reg;
    logic signed [eae_pkg::FIELD_W-1:0]  center_reg;
    logic [PW-1:0]                       round_sum;
    logic [eae_pkg::FIELD_W-1:0]         mag;
    logic signed [eae_pkg::COORD_W:0]    offset;
    logic signed [eae_pkg::COORD_W:0]    total;
    logic signed [eae_pkg::COORD_W-1:0]  value_reg;

    always_ff @(posedge clk)
    begin
        prod_reg   <= PW'(full) * PW'(trig);
        ctl_reg    <= ctl;
        center_reg <= center;
        value_reg  <= total[eae_pkg::COORD_W-1:0];
    end

    // magnitude of (P*sign + half) / 2^(F+1) truncated toward zero
    always_comb
    begin
        if (!ctl_reg.trig_neg)
        begin
            round_sum = prod_reg + HALF;
        end
        else if (prod_reg > HALF)
        begin
            round_sum = prod_reg - HALF;
        end
        else
        begin
            round_sum = '0;
        end
        mag    = round_sum[PW-1:FRAC_BITS+1];
        offset = ctl_reg.positive ? $signed({2'b00, mag}) : -$signed({2'b00, mag});
        total  = (eae_pkg::COORD_W+1)'(center_reg) + offset;
    end

    assign value = value_reg;

endmodule

@@ rtl/core/ellipse_arc_endpoints_core.sv @@
// Top level of the ellipse arc end point core: table load, input stage, table RAMs, axes.
// Depends on eae_pkg, eae_ram, eae_angle and eae_axis.
`timescale 1ns / 1ps

// Usage
//   Input: drive the rectangle, centre and angle fields with start high; the
//   transaction is taken at a rising edge where start is high and busy is low.
//   Output: done is high for exactly one cycle with first_x/first_y (computed end
//   point) and second_x/second_y (computed start point). The receiver cannot
//   stall; every result must be taken in the cycle it is shown.
// Throughput: one transaction per cycle, with no gaps, once the table is loaded.
// Pipeline: input register at the accepting edge, then table RAM read, multiply
//   register and output register; done rises when the output register loads the
//   result.
// Reset: rst_n low clears the valid flags and restarts the table load. After release
//   the quarter-wave sine table is written into both table RAMs, one entry a cycle,
//   91 entries in all; busy stays high during that sweep and no transaction is taken.
//   The two RAMs (one per arc point) each serve two reads a cycle, k and 90-k,
//   which set the one-item-per-cycle rate.
module ellipse_arc_endpoints_core #(
    parameter int TRIG_FRACTION_BITS = eae_pkg::TRIG_FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [eae_pkg::FIELD_W-1:0]  rect_left,
    input  logic signed [eae_pkg::FIELD_W-1:0]  rect_top,
    input  logic signed [eae_pkg::FIELD_W-1:0]  rect_right,
    input  logic signed [eae_pkg::FIELD_W-1:0]  rect_bottom,
    input  logic signed [eae_pkg::FIELD_W-1:0]  center_x,
    input  logic signed [eae_pkg::FIELD_W-1:0]  center_y,
    input  logic signed [eae_pkg::ANGLE_W-1:0]  start_angle,
    input  logic signed [eae_pkg::ANGLE_W-1:0]  arc_angle,
    output logic                                done,
    output logic signed [eae_pkg::COORD_W-1:0]  first_x,
    output logic signed [eae_pkg::COORD_W-1:0]  first_y,
    output logic signed [eae_pkg::COORD_W-1:0]  second_x,
    output logic signed [eae_pkg::COORD_W-1:0]  second_y
);

    localparam int TW = TRIG_FRACTION_BITS + 1;  // entry 90 is 2^F
    localparam int FW = eae_pkg::FIELD_W;
    localparam int AW = eae_pkg::TABLE_ADDR_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(eae_pkg::TABLE_DEPTH - 1);

    // ------------------------------------------------------------------
    // Table load sequencer: sweep every entry once after reset
    // ------------------------------------------------------------------
    logic          fill_active_reg, fill_active_next;
    logic [AW-1:0] fill_idx_reg, fill_idx_next;
    logic [15:0]   fill_q15;
    logic [31:0]   fill_wide;
    logic [TW-1:0] fill_data;

    always_comb
    begin
        fill_active_next = fill_active_reg;
        fill_idx_next    = fill_idx_reg;
        if (fill_active_reg)
        begin
            if (fill_idx_reg == LAST_IDX)
            begin
                fill_active_next = 1'b0;
            end
            else
            begin
                fill_idx_next = fill_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_active_reg <= 1'b1;
            fill_idx_reg    <= '0;
        end
        else
        begin
            fill_active_reg <= fill_active_next;
            fill_idx_reg    <= fill_idx_next;
        end
    end

    assign fill_q15 = eae_pkg::sine_q15(fill_idx_reg);

    // Rescale Q1.15 entries to the configured fraction width
    generate
        if (TRIG_FRACTION_BITS >= 15)
        begin : g_widen
            assign fill_wide = 32'(fill_q15) << (TRIG_FRACTION_BITS - 15);
        end
        else
        begin : g_narrow
            // round half up
            assign fill_wide = ((32'(fill_q15) >> (14 - TRIG_FRACTION_BITS)) + 32'd1) >> 1;
        end
    endgenerate

    assign fill_data = fill_wide[TW-1:0];
    assign busy      = fill_active_reg;

    // ------------------------------------------------------------------
    // Stage 1: capture the transaction
    // ------------------------------------------------------------------
    logic accept;
    logic v1_reg, v1_next;
    logic signed [FW-1:0] left_reg, top_reg, right_reg, bottom_reg, cx1_reg, cy1_reg;
    logic signed [eae_pkg::ANGLE_W-1:0] sa_reg, arc_reg;

    assign accept  = start && !busy;
    assign v1_next = accept;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg   <= rect_left;
            top_reg    <= rect_top;
            right_reg  <= rect_right;
            bottom_reg <= rect_bottom;
            cx1_reg    <= center_x;
            cy1_reg    <= center_y;
            sa_reg     <= start_angle;
            arc_reg    <= arc_angle;
        end
    end

    // Extents and angle decode; issue the table reads
    logic signed [FW:0]  w_diff, h_diff;
    logic [FW-1:0]       w_abs, h_abs;
    eae_pkg::eae_point_t start_pt, end_pt;

    always_comb
    begin
        w_diff = (FW+1)'(right_reg) - (FW+1)'(left_reg);
        h_diff = (FW+1)'(bottom_reg) - (FW+1)'(top_reg);
        w_abs  = w_diff[FW] ? FW'(-w_diff) : FW'(w_diff);
        h_abs  = h_diff[FW] ? FW'(-h_diff) : FW'(h_diff);
    end

    eae_angle u_angle (
        .start_angle (sa_reg),
        .arc_angle   (arc_reg),
        .start_pt    (start_pt),
        .end_pt      (end_pt)
    );

    logic [TW-1:0] s_rd_a, s_rd_b, e_rd_a, e_rd_b;

    eae_ram #(
        .WIDTH (TW),
        .DEPTH (eae_pkg::TABLE_DEPTH)
    ) u_ram_start (
        .clk     (clk),
        .we      (fill_active_reg),
        .waddr   (fill_idx_reg),
        .wdata   (fill_data),
        .raddr_a (start_pt.addr_a),
        .raddr_b (start_pt.addr_b),
        .rdata_a (s_rd_a),
        .rdata_b (s_rd_b)
    );

    eae_ram #(
        .WIDTH (TW),
        .DEPTH (eae_pkg::TABLE_DEPTH)
    ) u_ram_end (
        .clk     (clk),
        .we      (fill_active_reg),
        .waddr   (fill_idx_reg),
        .wdata   (fill_data),
        .raddr_a (end_pt.addr_a),
        .raddr_b (end_pt.addr_b),
        .rdata_a (e_rd_a),
        .rdata_b (e_rd_b)
    );

    // ------------------------------------------------------------------
    // Stage 2: table data arrives; hold side information alongside it
    // ------------------------------------------------------------------
    logic v2_reg, v3_reg, done_reg;
    logic [FW-1:0]        w2_reg, h2_reg;
    logic signed [FW-1:0] cx2_reg, cy2_reg;
    eae_pkg::eae_point_t  spt_reg, ept_reg;

    always_ff @(posedge clk)
    begin
        w2_reg  <= w_abs;
        h2_reg  <= h_abs;
        cx2_reg <= cx1_reg;
        cy2_reg <= cy1_reg;
        spt_reg <= start_pt;
        ept_reg <= end_pt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v1_next;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // Odd quadrants swap which port carries sine and which cosine
    logic [TW-1:0] s_cos, s_sin, e_cos, e_sin;
    eae_pkg::eae_axis_ctl_t sx_ctl, sy_ctl, ex_ctl, ey_ctl;

    always_comb
    begin
        s_cos = spt_reg.odd ? s_rd_a : s_rd_b;
        s_sin = spt_reg.odd ? s_rd_b : s_rd_a;
        e_cos = ept_reg.odd ? e_rd_a : e_rd_b;
        e_sin = ept_reg.odd ? e_rd_b : e_rd_a;

        sx_ctl.trig_neg = spt_reg.c_neg;
        sx_ctl.positive = spt_reg.x_pos;
        sy_ctl.trig_neg = spt_reg.s_neg;
        sy_ctl.positive = spt_reg.y_pos;
        ex_ctl.trig_neg = ept_reg.c_neg;
        ex_ctl.positive = ept_reg.x_pos;
        ey_ctl.trig_neg = ept_reg.s_neg;
        ey_ctl.positive = ept_reg.y_pos;
    end

    // ------------------------------------------------------------------
    // Stages 3 and 4: multiply, round, force sign, add centre
    // ------------------------------------------------------------------
    eae_axis #(.FRAC_BITS (TRIG_FRACTION_BITS)) u_start_x (
        .clk (clk), .full (w2_reg), .trig (s_cos), .ctl (sx_ctl),
        .center (cx2_reg), .value (second_x)
    );

    eae_axis #(.FRAC_BITS (TRIG_FRACTION_BITS)) u_start_y (
        .clk (clk), .full (h2_reg), .trig (s_sin), .ctl (sy_ctl),
        .center (cy2_reg), .value (second_y)
    );

    eae_axis #(.FRAC_BITS (TRIG_FRACTION_BITS)) u_end_x (
        .clk (clk), .full (w2_reg), .trig (e_cos), .ctl (ex_ctl),
        .center (cx2_reg), .value (first_x)
    );

    eae_axis #(.FRAC_BITS (TRIG_FRACTION_BITS)) u_end_y (
        .clk (clk), .full (h2_reg), .trig (e_sin), .ctl (ey_ctl),
        .center (cy2_reg), .value (first_y)
    );

    assign done = done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && !busy, 4))
        else $error("done does not follow an accepted transaction by four cycles");

    a_no_done_in_fill : assert property (@(posedge clk) disable iff (!rst_n)
        fill_active_reg |-> !done)
        else $error("result strobe during table load");

    a_fill_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        fill_active_reg |-> (fill_idx_reg <= LAST_IDX))
        else $error("table load address beyond table depth");

    a_fill_complete : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> ($past(fill_idx_reg) == LAST_IDX))
        else $error("table load ended before the last entry");

endmodule

@@ tb/eae_arc_checker.sv @@
// Arc end point checker: predicts each accepted transaction and compares the strobed result.
// Depends on eae_pkg for field widths and angle constants; holds its own sine table.
`timescale 1ns / 1ps

module eae_arc_checker #(
    parameter int TRIG_FRACTION_BITS = eae_pkg::TRIG_FRAC_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic signed [eae_pkg::FIELD_W-1:0] rect_left,
    input  logic signed [eae_pkg::FIELD_W-1:0] rect_top,
    input  logic signed [eae_pkg::FIELD_W-1:0] rect_right,
    input  logic signed [eae_pkg::FIELD_W-1:0] rect_bottom,
    input  logic signed [eae_pkg::FIELD_W-1:0] center_x,
    input  logic signed [eae_pkg::FIELD_W-1:0] center_y,
    input  logic signed [eae_pkg::ANGLE_W-1:0] start_angle,
    input  logic signed [eae_pkg::ANGLE_W-1:0] arc_angle,
    input  logic                               done,
    input  logic signed [eae_pkg::COORD_W-1:0] first_x,
    input  logic signed [eae_pkg::COORD_W-1:0] first_y,
    input  logic signed [eae_pkg::COORD_W-1:0] second_x,
    input  logic signed [eae_pkg::COORD_W-1:0] second_y,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 checked
);

    localparam int TURN = eae_pkg::DEGREES_PER_TURN;
    localparam int QTR  = eae_pkg::QUARTER_TURN;
    localparam int HALF = eae_pkg::HALF_TURN;
    localparam int TQTR = eae_pkg::THREE_QUARTER_TURN;
    localparam int CW   = eae_pkg::COORD_W;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [eae_pkg::COORD_W-1:0] first_x;
        logic signed [eae_pkg::COORD_W-1:0] first_y;
        logic signed [eae_pkg::COORD_W-1:0] second_x;
        logic signed [eae_pkg::COORD_W-1:0] second_y;
    } arc_pts_t;

    // sine of 0..90 degrees, Q1.15
    int unsigned quarter_sine [0:90] = '{
        0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
        5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32768
    };

    arc_pts_t pending_arcs [$];

    function automatic longint sine_at(input int k);
        longint raw;
        raw = longint'(quarter_sine[k]);
        if (TRIG_FRACTION_BITS >= 15)
            return raw << (TRIG_FRACTION_BITS - 15);
        return ((raw >> (14 - TRIG_FRACTION_BITS)) + 1) >> 1;
    endfunction

    // compass angle to screen angle
    function automatic int screen_angle(input int a);
        if (a <= QTR)
            return QTR - a;
        return TURN + QTR - a;
    endfunction

    // one end point: rounded axis offsets, sign forced by the quadrant, center added
    function automatic void project_point(input int a, input longint w, input longint h,
                                          input longint cx, input longint cy,
                                          output longint px, output longint py);
        longint c;
        longint s;
        longint ox;
        longint oy;
        int     r;
        int     k;
        logic   xpos;
        logic   ypos;
        xpos = 1'b0;
        ypos = 1'b0;
        if (a <= QTR)
            xpos = 1'b1;
        else if (a <= HALF)
            xpos = 1'b0;
        else if (a <= TQTR)
            ypos = 1'b1;
        else if (a <= TURN)
        begin
            xpos = 1'b1;
            ypos = 1'b1;
        end
        r = (a < 0 ? 0 : a) % TURN;
        k = r % QTR;
        case (r / QTR)
            0:
            begin
                s = sine_at(k);
                c = sine_at(QTR - k);
            end
            1:
            begin
                s = sine_at(QTR - k);
                c = -sine_at(k);
            end
            2:
            begin
                s = -sine_at(k);
                c = -sine_at(QTR - k);
            end
            default:
            begin
                s = -sine_at(QTR - k);
                c = sine_at(k);
            end
        endcase
        ox = (w * c + (longint'(1) << TRIG_FRACTION_BITS))
             / (longint'(1) << (TRIG_FRACTION_BITS + 1));
        oy = (h * s + (longint'(1) << TRIG_FRACTION_BITS))
             / (longint'(1) << (TRIG_FRACTION_BITS + 1));
        if (ox < 0)
            ox = -ox;
        if (oy < 0)
            oy = -oy;
        px = cx + (xpos ? ox : -ox);
        py = cy + (ypos ? oy : -oy);
    endfunction

    function automatic arc_pts_t arc_endpoints(
        input logic signed [eae_pkg::FIELD_W-1:0] l, t, r, b, cx, cy,
        input logic signed [eae_pkg::ANGLE_W-1:0] sa_in, ar_in);
        longint   w;
        longint   h;
        longint   sx;
        longint   sy;
        longint   ex;
        longint   ey;
        int       sa;
        int       ea;
        arc_pts_t p;
        w = longint'(r) - longint'(l);
        h = longint'(b) - longint'(t);
        if (w < 0)
            w = -w;
        if (h < 0)
            h = -h;
        ea = (int'(sa_in) + int'(ar_in)) % TURN;
        sa = screen_angle(int'(sa_in));
        ea = screen_angle(ea);
        if (sa < 0)
            sa += TURN;
        project_point(sa, w, h, longint'(cx), longint'(cy), sx, sy);
        project_point(ea, w, h, longint'(cx), longint'(cy), ex, ey);
        // clockwise arc: end point goes out first
        p.first_x  = CW'(ex);
        p.first_y  = CW'(ey);
        p.second_x = CW'(sx);
        p.second_y = CW'(sy);
        return p;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        arc_pts_t got;
        arc_pts_t want;
        if (!rst_n)
        begin
            pending_arcs.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                got = '{first_x, first_y, second_x, second_y};
                if (pending_arcs.size() == 0)
                    report_failure($sformatf("unexpected result (%0d,%0d) (%0d,%0d)",
                                             got.first_x, got.first_y,
                                             got.second_x, got.second_y));
                else
                begin
                    want = pending_arcs.pop_front();
                    checked++;
                    if (got != want)
                        report_failure($sformatf(
                            "result %0d: exp (%0d,%0d) (%0d,%0d) got (%0d,%0d) (%0d,%0d)",
                            checked, want.first_x, want.first_y, want.second_x,
                            want.second_y, got.first_x, got.first_y,
                            got.second_x, got.second_y));
                end
            end
            if (start && !busy)
                pending_arcs.push_back(arc_endpoints(rect_left, rect_top, rect_right,
                                                     rect_bottom, center_x, center_y,
                                                     start_angle, arc_angle));
            pending = pending_arcs.size();
        end
    end

endmodule

@@ tb/ellipse_arc_endpoints_core_test.sv @@
// Top of the ellipse arc end point testbench: clock, reset, stimulus and the verdict.
// Depends on eae_pkg, the ellipse_arc_endpoints_core RTL and eae_arc_checker.
`timescale 1ns / 1ps

module ellipse_arc_endpoints_core_test;

    localparam int FRAC_BITS    = eae_pkg::TRIG_FRAC_BITS_DEFAULT;
    localparam int FW           = eae_pkg::FIELD_W;
    localparam int AW           = eae_pkg::ANGLE_W;
    localparam int CW           = eae_pkg::COORD_W;
    localparam int RANDOM_ITEMS = 1150;
    // Table sweep after reset and ~1.2k transactions with gaps and drains stay far
    // below this limit in a correct run, so it only trips on a hang.
    localparam int CYCLE_LIMIT  = 200000;
    // After the final drain the bench keeps running for TAIL_CYCLES to catch any
    // stray strobe.
    localparam int TAIL_CYCLES  = 12;
    localparam int ANGLE_MAX    = eae_pkg::DEGREES_PER_TURN;

    localparam logic signed [FW-1:0] FMIN = {1'b1, {(FW-1){1'b0}}};
    localparam logic signed [FW-1:0] FMAX = {1'b0, {(FW-1){1'b1}}};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;

    logic signed [FW-1:0] rect_left   = '0;
    logic signed [FW-1:0] rect_top    = '0;
    logic signed [FW-1:0] rect_right  = '0;
    logic signed [FW-1:0] rect_bottom = '0;
    logic signed [FW-1:0] center_x    = '0;
    logic signed [FW-1:0] center_y    = '0;
    logic signed [AW-1:0] start_angle = '0;
    logic signed [AW-1:0] arc_angle   = '0;

    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;

    int fail_count;
    int pending;
    int checked;
    int cycle_count    = 0;
    int directed_sent  = 0;
    int random_sent    = 0;
    int drains         = 0;

    ellipse_arc_endpoints_core #(
        .TRIG_FRACTION_BITS(FRAC_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .rect_left  (rect_left),
        .rect_top   (rect_top),
        .rect_right (rect_right),
        .rect_bottom(rect_bottom),
        .center_x   (center_x),
        .center_y   (center_y),
        .start_angle(start_angle),
        .arc_angle  (arc_angle),
        .done       (done),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y)
    );

    // Checker sits beside the DUT on the same wires: it predicts every accepted
    // transaction and scores every done strobe.
    eae_arc_checker #(
        .TRIG_FRACTION_BITS(FRAC_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .rect_left  (rect_left),
        .rect_top   (rect_top),
        .rect_right (rect_right),
        .rect_bottom(rect_bottom),
        .center_x   (center_x),
        .center_y   (center_y),
        .start_angle(start_angle),
        .arc_angle  (arc_angle),
        .done       (done),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a result that never shows ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Present one transaction at the falling edge and hold it until the rising
    // edge where busy is low takes it. start is left high so the next call can
    // follow back to back; the busy window after reset is covered here too.
    task automatic drive_arc(input logic signed [FW-1:0] l, t, r, b, cx, cy,
                             input int sa, ar);
        @(negedge clk);
        rect_left   <= l;
        rect_top    <= t;
        rect_right  <= r;
        rect_bottom <= b;
        center_x    <= cx;
        center_y    <= cy;
        start_angle <= AW'(sa);
        arc_angle   <= AW'(ar);
        start       <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start for the whole gap and toggle the fields meanwhile; the DUT must
    // ignore whatever sits on the bus while start is low.
    task automatic idle_gap(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start       <= 1'b0;
            rect_left   <= FW'($urandom);
            rect_top    <= FW'($urandom);
            rect_right  <= FW'($urandom);
            rect_bottom <= FW'($urandom);
            center_x    <= FW'($urandom);
            center_y    <= FW'($urandom);
            start_angle <= AW'($urandom);
            arc_angle   <= AW'($urandom);
        end
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain_arcs();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        drains++;
    endtask

    // Full-size rectangle with a random center, for the angle sweep.
    task automatic full_rect_arc(input int sa, ar);
        drive_arc(FMIN, FMIN, FMAX, FMAX, FW'($urandom), FW'($urandom), sa, ar);
        directed_sent++;
    endtask

    // Angles mostly uniform over the legal range; a quarter of them land on or
    // next to a multiple of 90, where quadrant and sign rules change.
    function automatic int random_angle();
        int a;
        if ($urandom_range(0, 3) == 0)
            a = 90 * $urandom_range(0, 8) - ANGLE_MAX + $urandom_range(0, 2) - 1;
        else
            a = $urandom_range(0, 2 * ANGLE_MAX) - ANGLE_MAX;
        if (a > ANGLE_MAX)
            a = ANGLE_MAX;
        if (a < -ANGLE_MAX)
            a = -ANGLE_MAX;
        return a;
    endfunction

    task automatic random_arc();
        logic signed [FW-1:0] l;
        logic signed [FW-1:0] t;
        logic signed [FW-1:0] r;
        logic signed [FW-1:0] b;
        logic signed [FW-1:0] cx;
        logic signed [FW-1:0] cy;
        int                   shape;
        shape = $urandom_range(0, 9);
        l  = FW'($urandom);
        t  = FW'($urandom);
        r  = FW'($urandom);
        b  = FW'($urandom);
        cx = FW'($urandom);
        cy = FW'($urandom);
        case (shape)
            0, 1:
            begin
                // tiny ellipse, possibly degenerate or inverted
                r = l + FW'($urandom_range(0, 40)) - FW'(20);
                b = t + FW'($urandom_range(0, 40)) - FW'(20);
            end
            2:
            begin
                // center sits in the middle of the rectangle
                cx = FW'((int'(l) + int'(r)) >>> 1);
                cy = FW'((int'(t) + int'(b)) >>> 1);
            end
            3:
            begin
                // rectangle at or near full span
                l = FMIN + FW'($urandom_range(0, 3));
                r = FMAX - FW'($urandom_range(0, 3));
                t = FMIN + FW'($urandom_range(0, 3));
                b = FMAX - FW'($urandom_range(0, 3));
            end
            default: ;
        endcase
        drive_arc(l, t, r, b, cx, cy, random_angle(), random_angle());
        random_sent++;
    endtask

    initial
    begin
        int burst;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Degenerate rectangles: both points collapse onto the center.
        drive_arc('0, '0, '0, '0, '0, '0, 0, 0);
        drive_arc(FW'(100), FW'(200), FW'(100), FW'(200), FW'(-5), FW'(7), 45, 30);
        // Extreme corners of the result range: +65535 and -65536 on each axis.
        drive_arc(FMIN, FMIN, FMAX, FMAX, FMAX, FMIN, 90, -90);
        drive_arc(FMAX, FMAX, FMIN, FMIN, FMIN, FMAX, 270, -90);
        // Tall and wide ellipses: x follows width, y follows height.
        drive_arc(FW'(-50), FW'(-20000), FW'(50), FW'(20000), '0, '0, 30, 60);
        drive_arc(FW'(-20000), FW'(-50), FW'(20000), FW'(50), FW'(1000), FW'(-1000),
                  -120, 200);
        directed_sent += 6;

        // Quadrant boundaries, full-turn wraps, and starts below -270 that
        // push the screen angle past a full turn.
        full_rect_arc(0, 0);
        full_rect_arc(90, 0);
        full_rect_arc(-90, 0);
        full_rect_arc(180, 0);
        full_rect_arc(-180, 180);
        full_rect_arc(270, 0);
        full_rect_arc(-270, 0);
        full_rect_arc(-271, 1);
        full_rect_arc(360, 0);
        full_rect_arc(-360, 0);
        full_rect_arc(1, -1);
        full_rect_arc(91, -1);
        full_rect_arc(-360, 360);
        full_rect_arc(360, -360);
        full_rect_arc(359, 360);
        full_rect_arc(-359, -360);
        full_rect_arc(135, 225);
        full_rect_arc(-1, -359);
        drain_arcs();

        // Random traffic in bursts; some bursts run into the next with no gap,
        // some end in a short idle, a few wait for the pipeline to empty.
        while (random_sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
                if (random_sent < RANDOM_ITEMS)
                    random_arc();
            case ($urandom_range(0, 9))
                0, 1, 2: ;
                9:       drain_arcs();
                default: idle_gap($urandom_range(1, 8));
            endcase
        end

        drain_arcs();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d directed and %0d random transactions, %0d pipeline drains;",
                 directed_sent, random_sent, drains);
        $display("%0d arc results scored, %0d mismatches.", checked, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
